// ----- rtl/cdt_pkg.sv -----
// Shared types and constants for the countdown timer with calibration.
package cdt_pkg;

  // Fixed field widths of the request, result and configuration channels
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 16;
  localparam int DebW = 8;
  localparam int HoldW = 16;
  localparam int OutCntW = 16;

  // Reset values and calibration window
  localparam int StartReset = 25 * 60;
  localparam int DebounceReset = 10;
  localparam int LongPressReset = 5000 / 10;
  localparam int CalLow = 200;
  localparam int CalHigh = 400;
  localparam int CalScale = 5;
  localparam int StableMax = 255;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SECOND = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 8'd1;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_BLINK     = 3'd1,
    EV_TRIGGER   = 3'd2,
    EV_STARTED   = 3'd3,
    EV_STOPPED   = 3'd4,
    EV_CAL_ENTER = 3'd5,
    EV_CAL_STORE = 3'd6
  } event_t;

  typedef struct packed {
    logic req_type;
    logic button_raw;
  } in_req_t;

  typedef struct packed {
    event_t              event_res;
    logic [OutCntW-1:0]  remaining;
    logic                calibrating;
    logic [OutCntW-1:0]  stored_value;
  } out_res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_req_t;

endpackage

// ----- rtl/cdt_chan_if.sv -----
// Valid/ready channel interface carrying one payload word.
interface cdt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/countdown_timer_with_calibration_core.sv -----
// Countdown timer core: button debounce, start/stop, calibration, second ticks.
//
// For each request (a button sample tick or a one-second tick), the next
// timer state is computed combinationally from the current state and the
// request, and the result is loaded into an output register when the
// request is accepted. A new request is accepted every cycle while the output
// register is empty or being drained, so the sustained rate is one request per
// cycle; only a stalled result consumer holds off new requests. Configuration
// writes are always accepted. COUNT_WIDTH sets the width of the countdown and
// of the stored start value; the result fields show their low 16 bits.
module countdown_timer_with_calibration_core #(
  parameter int COUNT_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  cdt_chan_if.sink   in_req,
  cdt_chan_if.source out_res,
  cdt_chan_if.sink   cfg_wr
);

  localparam int CW = COUNT_WIDTH;

  // Configuration registers
  logic [cdt_pkg::DebW-1:0]  debounce_r;
  logic [cdt_pkg::HoldW-1:0] long_press_r;

  // Timer state
  logic                      deb_level_r, deb_level_nxt;
  logic                      cand_level_r, cand_level_nxt;
  logic [cdt_pkg::DebW-1:0]  stable_cnt_r, stable_cnt_nxt;
  logic [CW-1:0]             remaining_r, remaining_nxt;
  logic                      cal_flag_r, cal_flag_nxt;
  logic                      hold_armed_r, hold_armed_nxt;
  logic [cdt_pkg::HoldW-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [CW-1:0]             start_val_r, start_val_nxt;

  // Result register
  logic              out_valid_r;
  cdt_pkg::out_res_t out_data_r;
  cdt_pkg::event_t   ev;

  logic in_fire;
  logic cfg_fire;

  // Scratch values for the next-state computation
  logic                      raw;
  logic [cdt_pkg::HoldW-1:0] hold_inc;
  logic [cdt_pkg::HoldW-1:0] hold_lim;
  logic [cdt_pkg::DebW-1:0]  deb_need;
  logic [CW-1:0]             secs;
  logic [CW+2:0]             secs_x5;
  logic [31:0]               rem_ext;
  logic [31:0]               start_ext;

  assign in_req.ready  = !out_valid_r || out_res.ready;
  assign in_fire       = in_req.valid && in_req.ready;
  assign cfg_wr.ready  = 1'b1;
  assign cfg_fire      = cfg_wr.valid;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  assign raw      = in_req.data.button_raw;
  assign hold_inc = hold_cnt_r + 1'b1;
  assign hold_lim = (long_press_r == '0) ? cdt_pkg::HoldW'(1) : long_press_r;
  assign deb_need = (debounce_r == '0) ? cdt_pkg::DebW'(1) : debounce_r;
  assign secs     = start_val_r - remaining_r;
  assign secs_x5  = {secs, 2'b00} + (CW+3)'(secs);

  // Compute the next state and the event for the current request
  always_comb begin
    deb_level_nxt  = deb_level_r;
    cand_level_nxt = cand_level_r;
    stable_cnt_nxt = stable_cnt_r;
    remaining_nxt  = remaining_r;
    cal_flag_nxt   = cal_flag_r;
    hold_armed_nxt = hold_armed_r;
    hold_cnt_nxt   = hold_cnt_r;
    start_val_nxt  = start_val_r;
    ev             = cdt_pkg::EV_NONE;

    if (in_req.data.req_type == cdt_pkg::REQ_SECOND) begin
      // Count down a running timer
      if (remaining_r != '0) begin
        remaining_nxt = remaining_r - 1'b1;
        if (remaining_r == CW'(1)) begin
          cal_flag_nxt   = 1'b0;
          hold_armed_nxt = 1'b0;
          hold_cnt_nxt   = '0;
          ev             = cdt_pkg::EV_TRIGGER;
        end else begin
          ev = cdt_pkg::EV_BLINK;
        end
      end
    end else begin
      // Track a long hold after a start
      if (hold_armed_r) begin
        if (raw) begin
          if (hold_inc >= hold_lim) begin
            cal_flag_nxt   = 1'b1;
            hold_armed_nxt = 1'b0;
            hold_cnt_nxt   = '0;
            ev             = cdt_pkg::EV_CAL_ENTER;
          end else begin
            hold_cnt_nxt = hold_inc;
          end
        end else begin
          hold_armed_nxt = 1'b0;
          hold_cnt_nxt   = '0;
        end
      end

      // Debounce the raw level
      if (raw == cand_level_r) begin
        if (stable_cnt_r != cdt_pkg::DebW'(cdt_pkg::StableMax)) begin
          stable_cnt_nxt = stable_cnt_r + 1'b1;
        end
      end else begin
        cand_level_nxt = raw;
        stable_cnt_nxt = cdt_pkg::DebW'(1);
      end

      // Act on a new debounced press: stop a running timer or start it
      if (stable_cnt_nxt >= deb_need && cand_level_nxt != deb_level_r) begin
        deb_level_nxt = cand_level_nxt;
        if (cand_level_nxt && ev == cdt_pkg::EV_NONE) begin
          if (remaining_r != '0) begin
            ev = cdt_pkg::EV_STOPPED;
            if (cal_flag_r && secs > CW'(cdt_pkg::CalLow) &&
                secs < CW'(cdt_pkg::CalHigh)) begin
              start_val_nxt = secs_x5[CW-1:0];
              ev            = cdt_pkg::EV_CAL_STORE;
            end
            remaining_nxt  = '0;
            cal_flag_nxt   = 1'b0;
            hold_armed_nxt = 1'b0;
            hold_cnt_nxt   = '0;
          end else begin
            remaining_nxt  = start_val_r;
            hold_armed_nxt = 1'b1;
            hold_cnt_nxt   = '0;
            ev             = cdt_pkg::EV_STARTED;
          end
        end
      end
    end
  end

  assign rem_ext   = 32'(remaining_nxt);
  assign start_ext = 32'(start_val_nxt);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= cdt_pkg::DebW'(cdt_pkg::DebounceReset);
      long_press_r <= cdt_pkg::HoldW'(cdt_pkg::LongPressReset);
    end else if (cfg_fire) begin
      case (cfg_wr.data.index)
        cdt_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wr.data.wdata[cdt_pkg::DebW-1:0];
        cdt_pkg::CFG_LONG_PRESS: long_press_r <= cfg_wr.data.wdata[cdt_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Advance timer state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_level_r  <= 1'b0;
      cand_level_r <= 1'b0;
      stable_cnt_r <= '0;
      remaining_r  <= '0;
      cal_flag_r   <= 1'b0;
      hold_armed_r <= 1'b0;
      hold_cnt_r   <= '0;
      start_val_r  <= CW'(cdt_pkg::StartReset);
    end else if (in_fire) begin
      deb_level_r  <= deb_level_nxt;
      cand_level_r <= cand_level_nxt;
      stable_cnt_r <= stable_cnt_nxt;
      remaining_r  <= remaining_nxt;
      cal_flag_r   <= cal_flag_nxt;
      hold_armed_r <= hold_armed_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      start_val_r  <= start_val_nxt;
    end
  end

  // Load the result register; drop valid once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.event_res    <= ev;
      out_data_r.remaining    <= rem_ext[cdt_pkg::OutCntW-1:0];
      out_data_r.calibrating  <= cal_flag_nxt;
      out_data_r.stored_value <= start_ext[cdt_pkg::OutCntW-1:0];
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the countdown timer core with calibration.
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cdt_chan_if #(.payload_t(cdt_pkg::in_req_t)) in_if ();
  cdt_chan_if #(.payload_t(cdt_pkg::out_res_t)) out_if ();
  cdt_chan_if #(.payload_t(cdt_pkg::cfg_req_t)) cfg_if ();

  countdown_timer_with_calibration_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_if),
    .out_res(out_if),
    .cfg_wr(cfg_if)
  );

  always #5 clk = ~clk;

  // Timer state as the block should hold it
  logic                        deb_level;
  logic                        cand_level;
  logic [cdt_pkg::DebW-1:0]    stable_cnt;
  logic [cdt_pkg::OutCntW-1:0] remain;
  logic                        cal_flag;
  logic                        hold_on;
  logic [cdt_pkg::HoldW-1:0]   hold_cnt;
  logic [cdt_pkg::OutCntW-1:0] start_val;
  logic [cdt_pkg::DebW-1:0]    cfg_deb;
  logic [cdt_pkg::HoldW-1:0]   cfg_lp;

  cdt_pkg::out_res_t pending_status[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_cnt = 0;
  int requests_sent = 0;

  function automatic int debounce_need();
    return (cfg_deb == 0) ? 1 : int'(cfg_deb);
  endfunction

  function automatic int long_need();
    return (cfg_lp == 0) ? 1 : int'(cfg_lp);
  endfunction

  // Apply one request to the timer state and return the status it reports
  function automatic cdt_pkg::out_res_t advance_timer(input cdt_pkg::in_req_t req);
    cdt_pkg::event_t ev;
    logic [cdt_pkg::OutCntW-1:0] elapsed;
    logic [31:0] scaled;
    ev = cdt_pkg::EV_NONE;
    if (req.req_type == cdt_pkg::REQ_SECOND) begin
      if (remain != 0) begin
        remain = remain - 1'b1;
        if (remain == 0) begin
          cal_flag = 1'b0;
          hold_on = 1'b0;
          hold_cnt = '0;
          ev = cdt_pkg::EV_TRIGGER;
        end else begin
          ev = cdt_pkg::EV_BLINK;
        end
      end
    end else begin
      // Long-press tracking runs on the raw level
      if (hold_on) begin
        if (req.button_raw) begin
          hold_cnt = hold_cnt + 1'b1;
          if (int'(hold_cnt) >= long_need()) begin
            cal_flag = 1'b1;
            hold_on = 1'b0;
            hold_cnt = '0;
            ev = cdt_pkg::EV_CAL_ENTER;
          end
        end else begin
          hold_on = 1'b0;
          hold_cnt = '0;
        end
      end
      // Debounce with a saturating run counter
      if (req.button_raw == cand_level) begin
        if (stable_cnt != cdt_pkg::StableMax[cdt_pkg::DebW-1:0])
          stable_cnt = stable_cnt + 1'b1;
      end else begin
        cand_level = req.button_raw;
        stable_cnt = cdt_pkg::DebW'(1);
      end
      if (int'(stable_cnt) >= debounce_need() && cand_level != deb_level) begin
        deb_level = cand_level;
        if (deb_level && ev == cdt_pkg::EV_NONE) begin
          if (remain != 0) begin
            ev = cdt_pkg::EV_STOPPED;
            if (cal_flag) begin
              elapsed = start_val - remain;
              if (elapsed > cdt_pkg::CalLow && elapsed < cdt_pkg::CalHigh) begin
                scaled = elapsed * cdt_pkg::CalScale;
                start_val = scaled[cdt_pkg::OutCntW-1:0];
                ev = cdt_pkg::EV_CAL_STORE;
              end
            end
            remain = '0;
            cal_flag = 1'b0;
            hold_on = 1'b0;
            hold_cnt = '0;
          end else begin
            remain = start_val;
            hold_on = 1'b1;
            hold_cnt = '0;
            ev = cdt_pkg::EV_STARTED;
          end
        end
      end
    end
    return '{event_res: ev, remaining: remain, calibrating: cal_flag,
             stored_value: start_val};
  endfunction

  // Drive result ready with random stalls
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result with the oldest predicted status
  always @(posedge clk) begin
    cdt_pkg::out_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: ev=%0d rem=%0d cal=%0b stored=%0d",
                   out_if.data.event_res, out_if.data.remaining,
                   out_if.data.calibrating, out_if.data.stored_value);
      end else begin
        want = pending_status.pop_front();
        if (out_if.data.event_res !== want.event_res ||
            out_if.data.remaining !== want.remaining ||
            out_if.data.calibrating !== want.calibrating ||
            out_if.data.stored_value !== want.stored_value) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch ev/rem/cal/st exp %0d/%0d/%0b/%0d got %0d/%0d/%0b/%0d",
                     want.event_res, want.remaining, want.calibrating,
                     want.stored_value, out_if.data.event_res,
                     out_if.data.remaining, out_if.data.calibrating,
                     out_if.data.stored_value);
        end
      end
    end
  end

  // Send one request, with random idle cycles ahead of it
  task automatic send_req(input cdt_pkg::in_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= req;
    do @(posedge clk); while (!in_if.ready);
    requests_sent++;
    pending_status.push_back(advance_timer(req));
  endtask

  task automatic send_sample(input logic lvl);
    send_req('{req_type: cdt_pkg::REQ_SAMPLE, button_raw: lvl});
  endtask

  task automatic send_second();
    send_req('{req_type: cdt_pkg::REQ_SECOND, button_raw: 1'($urandom_range(1))});
  endtask

  task automatic sample_run(input logic lvl, input int n);
    repeat (n) send_sample(lvl);
  endtask

  // Seconds with the button held at lvl between them
  task automatic tick_run(input int n, input logic lvl);
    repeat (n) begin
      if ($urandom_range(3) == 0) send_sample(lvl);
      send_second();
    end
  endtask

  // Release fully, then press and hold for extra samples after the press
  task automatic press_button(input int extra);
    sample_run(1'b0, debounce_need());
    sample_run(1'b1, debounce_need() + extra);
  endtask

  task automatic stop_if_running();
    if (remain != 0) press_button(0);
  endtask

  // Drop valid and wait until every predicted status has come back
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input logic [cdt_pkg::DebW-1:0] deb,
                            input logic [cdt_pkg::HoldW-1:0] lp);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= cdt_pkg::cfg_req_t'{
      index: cdt_pkg::CFG_DEBOUNCE,
      wdata: {{(cdt_pkg::CfgDataW-cdt_pkg::DebW){1'b0}}, deb}};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_deb = deb;
    cfg_if.data <= cdt_pkg::cfg_req_t'{index: cdt_pkg::CFG_LONG_PRESS, wdata: lp};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_lp = lp;
    cfg_if.valid <= 1'b0;
  endtask

  // Elapsed seconds for a calibration run, biased toward the window edges
  function automatic int pick_secs();
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(5))
        0: return cdt_pkg::CalLow - 1;
        1: return cdt_pkg::CalLow;
        2: return cdt_pkg::CalLow + 1;
        3: return cdt_pkg::CalHigh - 1;
        4: return cdt_pkg::CalHigh;
        default: return cdt_pkg::CalHigh + 1;
      endcase
    end
    return $urandom_range(150, 420);
  endfunction

  // Start, long-press into calibration, count seconds, then stop
  task automatic calibration_cycle(input int secs);
    stop_if_running();
    press_button(long_need());
    sample_run(1'b0, debounce_need());
    tick_run(secs, 1'b0);
    press_button(0);
    sample_run(1'b0, debounce_need());
  endtask

  task automatic short_session();
    stop_if_running();
    press_button($urandom_range(0, long_need() + 2));
    sample_run(1'b0, $urandom_range(1, debounce_need() + 2));
    tick_run($urandom_range(0, 30), 1'b0);
    press_button(0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 40))
      send_req('{req_type: 1'($urandom_range(1)), button_raw: 1'($urandom_range(1))});
  endtask

  task automatic random_mix(input int budget);
    int stop_at;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      case ($urandom_range(3))
        0: calibration_cycle(pick_secs());
        3: noise_burst();
        default: short_session();
      endcase
    end
  endtask

  // Reset defaults, zero limits, every event except trigger and store
  task automatic test_directed_edges();
    send_idle_pct = 0;
    stall_pct = 0;
    send_req('{req_type: cdt_pkg::REQ_SECOND, button_raw: 1'b1});
    send_sample(1'b0);
    wait_idle();
    set_config('0, '0);
    send_sample(1'b1);
    send_sample(1'b1);
    send_req('{req_type: cdt_pkg::REQ_SECOND, button_raw: 1'b0});
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_second();
    send_sample(1'b1);
    send_sample(1'b0);
    send_second();
  endtask

  // Low-extreme limits, no idling; end on an in-window calibration store
  task automatic test_calibration_store();
    send_idle_pct = 0;
    stall_pct = 0;
    wait_idle();
    set_config(8'd1, 16'd1);
    random_mix(80);
    calibration_cycle($urandom_range(cdt_pkg::CalLow + 1, cdt_pkg::CalLow + 5));
  endtask

  // High-extreme limits; hold the button through a full countdown to expiry
  task automatic test_expiry_under_hold();
    send_idle_pct = 83;
    stall_pct = 0;
    wait_idle();
    set_config(8'd255, 16'hFFFF);
    stop_if_running();
    if (deb_level) sample_run(1'b0, debounce_need());
    sample_run(1'b1, debounce_need());
    while (remain != 0) begin
      if ($urandom_range(15) == 0) send_sample(1'b1);
      send_second();
    end
    sample_run(1'b0, 4);
  endtask

  // Mid-range limits under receiver stalls, then stalls on both sides
  task automatic test_random_stalls();
    send_idle_pct = 0;
    stall_pct = 83;
    wait_idle();
    set_config(cdt_pkg::DebW'($urandom_range(2, 6)), cdt_pkg::HoldW'($urandom_range(2, 20)));
    random_mix(30);
    send_idle_pct = 25;
    stall_pct = 25;
    wait_idle();
    set_config(cdt_pkg::DebW'($urandom_range(1, 12)), cdt_pkg::HoldW'($urandom_range(1, 40)));
    random_mix(30);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    deb_level = 1'b0;
    cand_level = 1'b0;
    stable_cnt = '0;
    remain = '0;
    cal_flag = 1'b0;
    hold_on = 1'b0;
    hold_cnt = '0;
    start_val = cdt_pkg::OutCntW'(cdt_pkg::StartReset);
    cfg_deb = cdt_pkg::DebW'(cdt_pkg::DebounceReset);
    cfg_lp = cdt_pkg::HoldW'(cdt_pkg::LongPressReset);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_calibration_store();
    test_expiry_under_hold();
    test_random_stalls();
    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("countdown_timer_with_calibration_core test passed");
    end else begin
      $display("countdown_timer_with_calibration_core test failed");
    end
    $finish;
  end

  // Hold a hard limit on run length
  initial begin
    #20000000;
    $display("countdown_timer_with_calibration_core test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cdt_pkg.sv
rtl/cdt_chan_if.sv
rtl/countdown_timer_with_calibration_core.sv
tb/sv/testbench.sv
